// ===== hw/rtl/radix_digit_string_converter_defines.svh =====
// Assertion macros shared by the radix digit string converter RTL.
// Define NO_ASSERTIONS to compile the checks away; no other dependencies.
`ifndef RADIX_DIGIT_STRING_CONVERTER_DEFINES_SVH
`define RADIX_DIGIT_STRING_CONVERTER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define RDSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rdsc check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RDSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rdsc check failed");

`else

`define RDSC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define RDSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/rdsc_pkg.sv =====
// Package for the radix digit string converter: widths, constants,
// controller/datapath interface structs and the digit-to-ASCII function.
// No dependencies.
`default_nettype none

package rdsc_pkg;

	// Field widths.
	localparam int VALUE_W = 64;
	localparam int RADIX_W = 6;
	localparam int CHAR_W  = 7;

	// Radix limits and reset value.
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

	// Default digit store depth.
	localparam int MAX_DIGITS_DEF = 64;

	// Character codes.
	localparam logic [RADIX_W-1:0] DEC_LIMIT  = 6'd9;
	localparam logic [RADIX_W-1:0] DEC_COUNT  = 6'd10;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0]  ASCII_A    = 7'd65;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic start;
		logic step;
		logic store;
		logic rd;
		logic load;
	} rdsc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic bit_last;
		logic done_next;
		logic out_free;
		logic last_digit;
	} rdsc_sts_t;

	// Maps a digit value to its ASCII character.
	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
		logic [RADIX_W-1:0] above;
		above = d - DEC_COUNT;
		if (d > DEC_LIMIT) begin
			return {1'b0, above} + ASCII_A;
		end else begin
			return {1'b0, d} + ASCII_ZERO;
		end
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/radix_digit_string_converter.sv =====
// Top level of the radix digit string converter: controller plus datapath.
// Depends on rdsc_pkg, rdsc_ctrl, rdsc_datapath and rdsc_ram.
//
//   Channel  Direction  Handshake             Payload
//   input    in         in_valid / in_stall   value[63:0]
//   output   out        out_valid / out_stall digit_char[6:0], last
//   config   in         cfg_we                cfg_data[5:0] (radix)
//
// Each digit comes out of the one-bit-per-cycle divider, then the digits
// are read back from the digit RAM through the read and load states. A value
// has at most MAX_DIGITS digits, 64 by default.
// The input stalls from acceptance until the last digit is in the output
// register. Output stalls hold the current beat and pause readback.
// Reset is asynchronous and sets the radix to ten; there is no clearing pass.
`default_nettype none

module radix_digit_string_converter #(
	parameter int MAX_DIGITS = rdsc_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [rdsc_pkg::RADIX_W-1:0]   cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic [rdsc_pkg::VALUE_W-1:0]   value,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic      [rdsc_pkg::CHAR_W-1:0]    digit_char,
	output logic                                last
);

	rdsc_pkg::rdsc_cmd_t cmd;
	rdsc_pkg::rdsc_sts_t sts;

	// Sequencing of division, storage and readback.
	rdsc_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	// Divider, digit store and output register.
	rdsc_datapath #(
		.MAX_DIGITS(MAX_DIGITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data),
		.value     (value),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.digit_char(digit_char),
		.last      (last)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/rdsc_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module rdsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rdsc_ctrl.sv =====
// Controller state machine of the radix digit string converter.
// Depends on rdsc_pkg for the command and status structs.
`default_nettype none

module rdsc_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire rdsc_pkg::rdsc_sts_t sts,
	output rdsc_pkg::rdsc_cmd_t    cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_READ,
		ST_LOAD
	} state_t;

	state_t state_q;

	// The input is open only between items.
	assign in_stall = (state_q != ST_IDLE);

	// Commands follow the state and the datapath status.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.start = in_valid;
			end
			ST_DIV: begin
				cmd.step  = 1'b1;
				cmd.store = sts.bit_last;
			end
			ST_READ: begin
				cmd.rd = 1'b1;
			end
			ST_LOAD: begin
				cmd.load = sts.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sts.bit_last && sts.done_next) begin
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					if (sts.out_free) begin
						state_q <= sts.last_digit ? ST_IDLE : ST_READ;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/rdsc_datapath.sv =====
// Datapath of the radix digit string converter: radix register, bit-serial
// divider, digit store, and output register. Depends on rdsc_pkg, rdsc_ram
// and the assertion macro header.
`default_nettype none
`include "radix_digit_string_converter_defines.svh"

module rdsc_datapath #(
	parameter int MAX_DIGITS = rdsc_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [rdsc_pkg::RADIX_W-1:0]      cfg_data,
	input  wire logic [rdsc_pkg::VALUE_W-1:0]      value,
	input  wire rdsc_pkg::rdsc_cmd_t               cmd,
	output rdsc_pkg::rdsc_sts_t                    sts,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [rdsc_pkg::CHAR_W-1:0]       digit_char,
	output logic                                   last
);

	localparam int CNT_W  = $clog2(MAX_DIGITS + 1);
	localparam int ADDR_W = $clog2(MAX_DIGITS);
	localparam int BIT_W  = $clog2(rdsc_pkg::VALUE_W);
	localparam int RW     = rdsc_pkg::RADIX_W;

	logic [RW-1:0]                radix_q;
	logic [RW-1:0]                eff_q;
	logic [RW-1:0]                eff_d;
	logic [rdsc_pkg::VALUE_W-1:0] n_q;
	logic [rdsc_pkg::VALUE_W-1:0] n_next;
	logic [RW-1:0]                rem_q;
	logic [RW-1:0]                rem_next;
	logic [RW:0]                  trial;
	logic [RW:0]                  diff;
	logic                         ge;
	logic [BIT_W-1:0]             bit_q;
	logic [CNT_W-1:0]             count_q;
	logic [CNT_W-1:0]             count_m1;
	logic [rdsc_pkg::CHAR_W-1:0]  ram_rdata;
	logic                         out_valid_q;
	logic [rdsc_pkg::CHAR_W-1:0]  digit_char_q;
	logic                         last_q;

	// Radix register; the user must write it only between items, the block does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= rdsc_pkg::RADIX_RESET;
		end else if (cfg_we) begin
			radix_q <= cfg_data;
		end
	end

	// Clamp the radix into the supported range.
	always_comb begin
		priority if (radix_q < rdsc_pkg::RADIX_MIN) begin
			eff_d = rdsc_pkg::RADIX_MIN;
		end else if (radix_q > rdsc_pkg::RADIX_MAX) begin
			eff_d = rdsc_pkg::RADIX_MAX;
		end else begin
			eff_d = radix_q;
		end
	end

	// One restoring division step: shift in the next dividend bit.
	assign trial    = {rem_q, n_q[rdsc_pkg::VALUE_W-1]};
	assign ge       = (trial >= {1'b0, eff_q});
	assign diff     = trial - {1'b0, eff_q};
	assign rem_next = ge ? diff[RW-1:0] : trial[RW-1:0];
	assign n_next   = {n_q[rdsc_pkg::VALUE_W-2:0], ge};
	assign count_m1 = count_q - CNT_W'(1);

	// Divider registers: dividend/quotient, remainder and effective radix.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			n_q   <= value;
			rem_q <= '0;
			eff_q <= eff_d;
		end else if (cmd.step) begin
			n_q   <= n_next;
			rem_q <= cmd.store ? '0 : rem_next;
		end
	end

	// Bit and digit counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q   <= '0;
			count_q <= '0;
		end else begin
			if (cmd.start) begin
				bit_q   <= '0;
				count_q <= '0;
			end else begin
				if (cmd.step) begin
					bit_q <= bit_q + BIT_W'(1);
				end
				if (cmd.store) begin
					count_q <= count_q + CNT_W'(1);
				end else if (cmd.rd) begin
					count_q <= count_m1;
				end
			end
		end
	end

	// Digit store: written least significant first, read back in reverse.
	rdsc_ram #(
		.WIDTH(rdsc_pkg::CHAR_W),
		.DEPTH(MAX_DIGITS)
	) u_ram (
		.clk  (clk),
		.we   (cmd.store),
		.waddr(count_q[ADDR_W-1:0]),
		.wdata(rdsc_pkg::digit_ascii(rem_next)),
		.re   (cmd.rd),
		.raddr(count_m1[ADDR_W-1:0]),
		.rdata(ram_rdata)
	);

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			digit_char_q <= ram_rdata;
			last_q       <= (count_q == '0);
		end
	end

	assign out_valid  = out_valid_q;
	assign digit_char = digit_char_q;
	assign last       = last_q;

	// Status back to the controller.
	assign sts.bit_last   = (bit_q == BIT_W'(rdsc_pkg::VALUE_W - 1));
	assign sts.done_next  = (n_next == '0) || (count_q == CNT_W'(MAX_DIGITS - 1));
	assign sts.out_free   = !out_valid_q || !out_stall;
	assign sts.last_digit = (count_q == '0);

	// A new beat is never loaded over one that is still held.
	`RDSC_ASSERT_IMPL(a_load_free, clk, arst_n, cmd.load, !out_valid_q || !out_stall)
	// A readback never runs past the first stored digit.
	`RDSC_ASSERT_IMPL(a_rd_nonempty, clk, arst_n, cmd.rd, count_q != '0)
	// Storing a digit restarts the remainder for the next division.
	`RDSC_ASSERT_NEXT(a_store_clear, clk, arst_n, cmd.store, rem_q == '0)
	// The digit count stays within the store.
	`RDSC_ASSERT_IMPL(a_count_range, clk, arst_n, cmd.store, count_q < CNT_W'(MAX_DIGITS))

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for radix_digit_string_converter: predicts the ASCII digit beats
// of each accepted value in the current radix and checks every output beat.
// Depends on rdsc_pkg and on the converter RTL only.
`timescale 1ns / 1ps

module testbench;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 300;
	localparam int PHASE_ITEMS    = 17;

	typedef struct packed {
		logic [rdsc_pkg::CHAR_W-1:0] digit_char;
		logic                        last;
	} digit_beat_t;

	logic                         clk       = 1'b0;
	logic                         arst_n    = 1'b0;
	logic                         cfg_we    = 1'b0;
	logic [rdsc_pkg::RADIX_W-1:0] cfg_data  = '0;
	logic                         in_valid  = 1'b0;
	logic                         in_stall;
	logic [rdsc_pkg::VALUE_W-1:0] value     = '0;
	logic                         out_valid;
	logic                         out_stall = 1'b0;
	logic [rdsc_pkg::CHAR_W-1:0]  digit_char;
	logic                         last;

	// Radix as last written, the expected digit beats and the error count.
	logic [rdsc_pkg::RADIX_W-1:0] radix_reg = rdsc_pkg::RADIX_RESET;
	digit_beat_t                  expected_digits[$];
	int                           mismatch_count = 0;

	// Knobs for idle cycles on the input side and stalls on the output side.
	bit                 gap_enable   = 1'b0;
	bit                 stall_enable = 1'b0;
	int                 stall_left   = 0;

	radix_digit_string_converter DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.digit_char (digit_char),
		.last       (last)
	);

	// Clock with a 12 ns period.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Length of an idle burst: mostly short, now and then long.
	function automatic int burst_length();
		if ($urandom_range(0, 9) == 0) begin
			return $urandom_range(10, 40);
		end
		return $urandom_range(1, 3);
	endfunction

	// Values spread over all magnitudes so that digit counts vary widely.
	function automatic logic [rdsc_pkg::VALUE_W-1:0] random_value();
		logic [rdsc_pkg::VALUE_W-1:0] v;
		int                           pick;
		v = {$urandom(), $urandom()};
		pick = $urandom_range(0, 3);
		if (pick == 1 || pick == 2) begin
			v = v >> $urandom_range(1, 63);
		end else if (pick == 3) begin
			v = v >> $urandom_range(48, 63);
		end
		return v;
	endfunction

	// Queues the digit beats of one value, most significant digit first.
	function automatic void expand_digits(input logic [rdsc_pkg::VALUE_W-1:0] v);
		logic [rdsc_pkg::VALUE_W-1:0] rest;
		logic [rdsc_pkg::VALUE_W-1:0] base;
		logic [rdsc_pkg::VALUE_W-1:0] d;
		logic [rdsc_pkg::CHAR_W-1:0]  held[64];
		digit_beat_t                  beat;
		int                           count;
		// Register values outside two through thirty-six are clamped.
		if (radix_reg < rdsc_pkg::RADIX_MIN) begin
			base = rdsc_pkg::VALUE_W'(rdsc_pkg::RADIX_MIN);
		end else if (radix_reg > rdsc_pkg::RADIX_MAX) begin
			base = rdsc_pkg::VALUE_W'(rdsc_pkg::RADIX_MAX);
		end else begin
			base = rdsc_pkg::VALUE_W'(radix_reg);
		end
		rest = v;
		count = 0;
		do begin
			d = rest % base;
			if (d > rdsc_pkg::VALUE_W'(rdsc_pkg::DEC_LIMIT)) begin
				held[count] = rdsc_pkg::ASCII_A +
					rdsc_pkg::CHAR_W'(d - rdsc_pkg::VALUE_W'(rdsc_pkg::DEC_COUNT));
			end else begin
				held[count] = rdsc_pkg::ASCII_ZERO + rdsc_pkg::CHAR_W'(d);
			end
			count++;
			rest = rest / base;
		end while (rest != 0 && count < 64);
		for (int k = count - 1; k >= 0; k--) begin
			beat.digit_char = held[k];
			beat.last = (k == 0);
			expected_digits.push_back(beat);
		end
	endfunction

	// Input monitor: every accepted beat is expanded into its digits.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expand_digits(value);
		end
	end

	// Output checker: every accepted beat is compared with the oldest expectation.
	always @(posedge clk) begin
		digit_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_digits.size() == 0) begin
				$display("%0t: unexpected beat, digit_char %0d last %0b",
					$time, digit_char, last);
				mismatch_count++;
			end else begin
				want = expected_digits.pop_front();
				if (digit_char !== want.digit_char) begin
					$display("%0t: digit_char expected %0d got %0d",
						$time, want.digit_char, digit_char);
					mismatch_count++;
				end
				if (last !== want.last) begin
					$display("%0t: last expected %0b got %0b", $time, want.last, last);
					mismatch_count++;
				end
			end
		end
	end

	// Output stall generator.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if (!stall_enable) begin
			out_stall <= 1'b0;
		end else if ($urandom_range(0, 1) == 0) begin
			out_stall <= 1'b0;
			stall_left <= $urandom_range(0, 4);
		end else begin
			out_stall <= 1'b1;
			stall_left <= burst_length() - 1;
		end
	end

	// Watchdog: ends the run when no beat moves for too long.
	initial begin
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("%0t: watchdog expired", $time);
		$display("Regression FAIL");
		$finish;
	end

	// Sends one value, returning at the edge where it is accepted.
	task automatic send_value(input logic [rdsc_pkg::VALUE_W-1:0] v);
		int gap;
		gap = 0;
		if (gap_enable && $urandom_range(0, 1) == 0) begin
			gap = burst_length();
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// Drops the input and waits until every expected digit has come out.
	task automatic wait_for_digits();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_digits.size() != 0) @(posedge clk);
	endtask

	// Writes the radix register once the converter has gone idle.
	task automatic write_radix(input logic [rdsc_pkg::RADIX_W-1:0] r);
		wait_for_digits();
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= r;
		@(posedge clk);
		cfg_we <= 1'b0;
		radix_reg = r;
	endtask

	// Decimal after reset: zero, one and two digits, and the widest values.
	task automatic test_default_radix();
		gap_enable = 1'b0;
		stall_enable = 1'b1;
		send_value(64'd0);
		send_value(64'd1);
		send_value(64'd9);
		send_value(64'd10);
		send_value(64'd255);
		send_value(64'h8AC7_2304_89E7_FFFF);
		send_value(64'h8AC7_2304_89E8_0000);
		send_value(64'hFFFF_FFFF_FFFF_FFFF);
	endtask

	// Smallest and largest radix, clamped register values and letter digits.
	task automatic test_radix_limits();
		gap_enable = 1'b1;
		write_radix(6'd2);
		send_value(64'd0);
		send_value(64'd1);
		send_value(64'h8000_0000_0000_0000);
		send_value(64'hFFFF_FFFF_FFFF_FFFF);
		write_radix(6'd36);
		send_value(64'd35);
		send_value(64'd36);
		send_value(64'd0);
		send_value(64'hFFFF_FFFF_FFFF_FFFF);
		// Register values below two behave as binary.
		write_radix(6'd0);
		send_value(64'd5);
		write_radix(6'd1);
		send_value(64'd2);
		// Register values above thirty-six behave as base thirty-six.
		write_radix(6'd37);
		send_value(64'd35);
		write_radix(6'd63);
		send_value(64'hFFFF_FFFF_FFFF_FFFF);
		write_radix(6'd16);
		send_value(64'h0123_4567_89AB_CDEF);
		send_value(64'hFEDC_BA98_7654_3210);
	endtask

	// Random values under a series of radix settings and idle patterns.
	task automatic test_random_values();
		logic [rdsc_pkg::RADIX_W-1:0] phase_radix;
		for (int phase = 0; phase < 7; phase++) begin
			unique case (phase)
				0: phase_radix = 6'd10;
				1: phase_radix = 6'd2;
				2: phase_radix = 6'd36;
				3: phase_radix = rdsc_pkg::RADIX_W'($urandom_range(0, 63));
				4: phase_radix = rdsc_pkg::RADIX_W'($urandom_range(2, 36));
				5: phase_radix = rdsc_pkg::RADIX_W'($urandom_range(37, 63));
				default: phase_radix = 6'd8;
			endcase
			write_radix(phase_radix);
			gap_enable = (phase != 0) && (phase != 3);
			stall_enable = (phase != 0) && (phase != 4);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				send_value(random_value());
			end
		end
	endtask

	// Test sequence and final verdict.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		test_default_radix();
		test_radix_limits();
		test_random_values();
		wait_for_digits();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
